FILE: rtl/skvs_pkg.sv
// shared types and constants for the sorted key/value set
`timescale 1ns / 1ps

package skvs_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int OP_W         = 2;

    localparam logic [OP_W-1:0]  OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0]  OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0]  OP_FIND   = 2'd2;

    localparam logic [KEY_W-1:0] SENTINEL_KEY = {KEY_W{1'b1}};

    // contents of one cell
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cell_data;

    // request broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cell_ctrl;

endpackage

FILE: rtl/skvs_cell.sv
// one cell of the sorted chain: holds a pair, compares it and shifts with its neighbors
`timescale 1ns / 1ps

module skvs_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  skvs_pkg::t_cell_ctrl  i_ctrl,
    input  skvs_pkg::t_cell_data  i_left,
    input  logic                  i_left_after,
    input  skvs_pkg::t_cell_data  i_right,
    output skvs_pkg::t_cell_data  o_data,
    output logic                  o_after,
    output logic                  o_hit
);
    import skvs_pkg::*;

    t_cell_data r_data;
    t_cell_data n_data;
    logic       w_ge;

    // keys are ascending over the valid prefix, so o_after is a thermometer along the chain
    assign w_ge    = r_data.valid && (r_data.key >= i_ctrl.key);
    assign o_after = w_ge || !r_data.valid;
    assign o_hit   = r_data.valid && (r_data.key == i_ctrl.key);
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (i_left_after) begin
                n_data = i_left;
            end else if (o_after) begin
                n_data.valid = 1'b1;
                n_data.key   = i_ctrl.key;
                n_data.value = i_ctrl.value;
            end
        end else if (i_ctrl.del) begin
            // the hit cell and everything above it close the gap
            if (o_after) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else begin
            r_data <= n_data;
        end
    end

endmodule

FILE: rtl/skvs_chain.sv
// row of cells with neighbor wiring and the reductions over the row
`timescale 1ns / 1ps

module skvs_chain #(
    parameter int CAPACITY = skvs_pkg::DEF_CAPACITY
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  skvs_pkg::t_cell_ctrl         i_ctrl,
    output logic                         o_hit,
    output logic [skvs_pkg::VAL_W-1:0]   o_hit_value,
    output logic                         o_full,
    output logic [CAPACITY-1:0]          o_valid
);
    import skvs_pkg::*;

    t_cell_data              w_data  [CAPACITY];
    t_cell_data              w_left  [CAPACITY];
    t_cell_data              w_right [CAPACITY];
    logic [CAPACITY-1:0]     w_after;
    logic [CAPACITY-1:0]     w_left_after;
    logic [CAPACITY-1:0]     w_hit;

    localparam t_cell_data EMPTY_CELL = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_left[g]       = EMPTY_CELL;
                assign w_left_after[g] = 1'b0;
            end else begin : g_mid
                assign w_left[g]       = w_data[g-1];
                assign w_left_after[g] = w_after[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right[g] = EMPTY_CELL;
            end else begin : g_inner
                assign w_right[g] = w_data[g+1];
            end

            skvs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (i_ctrl),
                .i_left       (w_left[g]),
                .i_left_after (w_left_after[g]),
                .i_right      (w_right[g]),
                .o_data       (w_data[g]),
                .o_after      (w_after[g]),
                .o_hit        (w_hit[g])
            );

            assign o_valid[g] = w_data[g].valid;
        end
    endgenerate

    // keys are unique, so at most one cell hits and an or of masked values selects it
    always_comb begin
        o_hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            o_hit_value = o_hit_value | (w_hit[i] ? w_data[i].value : '0);
        end
    end

    assign o_hit  = |w_hit && (i_ctrl.key != SENTINEL_KEY);
    assign o_full = w_data[CAPACITY-1].valid;

endmodule

FILE: rtl/sorted_key_value_set.sv
// Sorted key/value set: a chain of CAPACITY cells holds unique keys in ascending order with
// their values. Every cell compares its key with the request at once, and an insert or delete
// shifts the upper part of the chain by one cell in the same cycle, so one item is taken per
// clock while s_axis_tready is high; each result is registered in an output register, and
// s_axis_tready stays high while that register is empty or being drained. The all-ones key
// never matches. No clearing pass is needed after reset: only valid flags are reset.
`timescale 1ns / 1ps

module sorted_key_value_set #(
    parameter int CAPACITY = skvs_pkg::DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // success[0], value_out[32:1], full_res[33], zero[39:34]
);
    import skvs_pkg::*;

    logic                r_out_valid;
    logic [39:0]         r_out_data;
    logic [39:0]         n_out_data;

    logic                w_fire;
    logic [OP_W-1:0]     w_op;
    logic [KEY_W-1:0]    w_key;
    logic [VAL_W-1:0]    w_value;
    t_cell_ctrl          w_ctrl;
    logic                w_hit;
    logic [VAL_W-1:0]    w_hit_value;
    logic                w_full;
    logic [CAPACITY-1:0] w_valid;
    logic                w_ins_try;
    logic                w_ins_ok;
    logic                w_del_ok;
    logic                w_read_ok;
    logic                w_success;
    logic                w_full_res;
    logic [VAL_W-1:0]    w_value_out;

    assign w_op    = s_axis_tuser;
    assign w_key   = s_axis_tdata[31:0];
    assign w_value = s_axis_tdata[63:32];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_fire        = s_axis_tvalid && s_axis_tready;

    assign w_ins_try = (w_op == OP_INSERT) && (w_key != SENTINEL_KEY) && !w_hit;
    assign w_ins_ok  = w_ins_try && !w_full;
    assign w_del_ok  = (w_op == OP_DELETE) && w_hit;
    assign w_read_ok = w_del_ok || ((w_op == OP_FIND) && w_hit);

    assign w_ctrl.ins   = w_fire && w_ins_ok;
    assign w_ctrl.del   = w_fire && w_del_ok;
    assign w_ctrl.key   = w_key;
    assign w_ctrl.value = w_value;

    skvs_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_hit       (w_hit),
        .o_hit_value (w_hit_value),
        .o_full      (w_full),
        .o_valid     (w_valid)
    );

    assign w_success   = w_ins_ok || w_read_ok;
    assign w_full_res  = w_ins_try && w_full;
    assign w_value_out = w_read_ok ? w_hit_value : '0;
    assign n_out_data  = {6'd0, w_full_res, w_value_out, w_success};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // occupied cells always form a prefix of the chain
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("valid cells are not a prefix");

    // a successful insert grows the set by exactly one entry
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ins |=> $countones(w_valid) == $past($countones(w_valid)) + 1)
        else $error("insert did not add one entry");

    // a successful delete shrinks the set by exactly one entry
    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.del |=> $countones(w_valid) + 1 == $past($countones(w_valid)))
        else $error("delete did not remove one entry");

    // a full report never comes with success
    a_full_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[33]))
        else $error("full result reported as success");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the sorted key/value set
`timescale 1ns / 1ps

module testbench;

    import skvs_pkg::*;

    localparam int CAPACITY   = DEF_CAPACITY;
    localparam int MAX_GAP    = 17;
    localparam int STALL_LIM  = 2000;
    localparam int HOLD_LEN   = 300;
    localparam int POOL_SIZE  = 48;
    localparam int FILL_KEYS  = CAPACITY + 4;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic             success;
        logic [VAL_W-1:0] value_out;
        logic             full_res;
    } t_set_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // key[31:0], value[63:32]
    logic [1:0]  s_axis_tuser = '0;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;        // success[0], value_out[32:1], full_res[33], zero[39:34]

    logic        sink_ready = 1'b1;
    logic        sink_hold  = 1'b0;
    bit          src_idle_on = 1'b1;
    bit          snk_idle_on = 1'b1;

    // shadow copy of the set, kept in ascending key order
    logic [KEY_W-1:0] shadow_keys [CAPACITY];
    logic [VAL_W-1:0] shadow_vals [CAPACITY];
    int               shadow_count = 0;

    t_set_result      expected_results [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int errors     = 0;
    int n_requests = 0;
    int n_results  = 0;
    int n_ins_ok   = 0;
    int n_full     = 0;
    int n_del_ok   = 0;
    int n_find_ok  = 0;
    int n_max_fill = 0;
    int quiet_cycles = 0;

    assign m_axis_tready = sink_ready && !sink_hold;

    sorted_key_value_set #(.CAPACITY(CAPACITY)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_gap(input bit enable);
        return enable ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // applies one request to the shadow set and returns the answer the block owes
    function automatic t_set_result apply_set_request(input logic [OP_W-1:0] op,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [VAL_W-1:0] val);
        t_set_result r;
        int slot;
        bit hit;
        r = '0;
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] < key)
            slot++;
        hit = (key != SENTINEL_KEY) && (slot < shadow_count) && (shadow_keys[slot] == key);
        case (op)
            OP_INSERT: begin
                if (key != SENTINEL_KEY && !hit) begin
                    if (shadow_count >= CAPACITY) begin
                        r.full_res = 1'b1;
                        n_full++;
                    end else begin
                        for (int i = shadow_count; i > slot; i--) begin
                            shadow_keys[i] = shadow_keys[i-1];
                            shadow_vals[i] = shadow_vals[i-1];
                        end
                        shadow_keys[slot] = key;
                        shadow_vals[slot] = val;
                        shadow_count++;
                        r.success = 1'b1;
                        n_ins_ok++;
                        if (shadow_count == CAPACITY)
                            n_max_fill++;
                    end
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    r.value_out = shadow_vals[slot];
                    r.success = 1'b1;
                    for (int i = slot; i + 1 < shadow_count; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_vals[i] = shadow_vals[i+1];
                    end
                    shadow_count--;
                    n_del_ok++;
                end
            end
            OP_FIND: begin
                if (hit) begin
                    r.value_out = shadow_vals[slot];
                    r.success = 1'b1;
                    n_find_ok++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        errors++;
        $display("%0t ERROR result %0d %s: expected %h got %h", $realtime, n_results, what,
                 exp_v, got_v);
    endtask

    // result check first, then prediction, so a same-edge item never matches its own result
    always @(posedge i_clk) begin
        t_set_result want;
        t_set_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.success   = m_axis_tdata[0];
            got.value_out = m_axis_tdata[32:1];
            got.full_res  = m_axis_tdata[33];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", '0, 64'(m_axis_tdata));
            end else begin
                want = expected_results.pop_front();
                if (got.success !== want.success)
                    report_mismatch("success", 64'(want.success), 64'(got.success));
                if (got.value_out !== want.value_out)
                    report_mismatch("value_out", 64'(want.value_out), 64'(got.value_out));
                if (got.full_res !== want.full_res)
                    report_mismatch("full_res", 64'(want.full_res), 64'(got.full_res));
            end
            n_results++;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_results.push_back(apply_set_request(s_axis_tuser, s_axis_tdata[31:0],
                                                         s_axis_tdata[63:32]));
            n_requests++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIM) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIM);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stall before each result while snk_idle_on is set
    initial begin : sink_proc
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = draw_gap(snk_idle_on);
            if (gap > 0) begin
                sink_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            sink_ready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] val);
        int gap;
        gap = draw_gap(src_idle_on);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, key};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 95)
            return $urandom;
        return SENTINEL_KEY;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int ins_w, input int del_w,
                                                input int find_w);
        int r;
        r = $urandom_range(0, ins_w + del_w + find_w + 4);
        if (r < ins_w)
            return OP_INSERT;
        else if (r < ins_w + del_w)
            return OP_DELETE;
        else if (r < ins_w + del_w + find_w)
            return OP_FIND;
        return OP_UNUSED;
    endfunction

    task automatic test_directed();
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        send_request(OP_FIND,   32'd5,          32'h1111_1111);
        send_request(OP_DELETE, 32'd5,          32'h2222_2222);
        send_request(OP_INSERT, 32'd0,          32'd0);
        send_request(OP_INSERT, 32'hFFFF_FFFE,  32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h8000_0000,  32'hA5A5_A5A5);
        send_request(OP_INSERT, 32'd0,          32'h1234_5678);   // duplicate key
        send_request(OP_INSERT, SENTINEL_KEY,   32'd1);
        send_request(OP_FIND,   SENTINEL_KEY,   32'd0);
        send_request(OP_DELETE, SENTINEL_KEY,   32'd0);
        send_request(OP_FIND,   32'd0,          32'hFFFF_FFFF);
        send_request(OP_FIND,   32'hFFFF_FFFE,  32'd0);
        send_request(OP_UNUSED, 32'd0,          32'h5A5A_5A5A);
        send_request(OP_UNUSED, 32'h8000_0000,  32'd0);
        send_request(OP_FIND,   32'h7FFF_FFFF,  32'd0);
        send_request(OP_DELETE, 32'h8000_0000,  32'd0);
        send_request(OP_FIND,   32'h8000_0000,  32'd0);
        send_request(OP_DELETE, 32'd0,          32'd0);
        send_request(OP_DELETE, 32'hFFFF_FFFE,  32'd0);
        send_request(OP_FIND,   32'd0,          32'd0);
    endtask

    // fills the set past capacity with distinct keys, probes it while full, then empties it
    task automatic test_full_store();
        logic [KEY_W-1:0] keys [FILL_KEYS];
        logic [KEY_W-1:0] k;
        bit dup;
        for (int i = 0; i < FILL_KEYS; i++) begin
            do begin
                k = $urandom;
                dup = (k == SENTINEL_KEY);
                for (int j = 0; j < i; j++)
                    if (keys[j] == k)
                        dup = 1'b1;
            end while (dup);
            keys[i] = k;
        end
        src_idle_on = 1'b0;
        snk_idle_on = 1'b1;
        for (int i = 0; i < FILL_KEYS; i++)
            send_request(OP_INSERT, keys[i], $urandom);
        src_idle_on = 1'b1;
        send_request(OP_INSERT, keys[3], $urandom);       // duplicate while full
        send_request(OP_INSERT, SENTINEL_KEY, $urandom);
        send_request(OP_FIND, keys[CAPACITY], $urandom);  // rejected key
        send_request(OP_FIND, keys[0], $urandom);
        for (int i = FILL_KEYS - 1; i >= 0; i--)
            send_request(OP_DELETE, keys[i], $urandom);
    endtask

    // phases lean toward insert, toward delete or are balanced, so the set swings between empty and full
    task automatic test_random(input int n_chunks, input int chunk_len);
        for (int c = 0; c < n_chunks; c++) begin
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            if (c % 4 == 3) begin
                src_idle_on = 1'b0;
                snk_idle_on = 1'b0;
            end
            for (int i = 0; i < chunk_len; i++) begin
                case (c % 3)
                    0: send_request(pick_op(60, 15, 20), pick_key(), $urandom);
                    1: send_request(pick_op(20, 50, 25), pick_key(), $urandom);
                    default: send_request(pick_op(35, 30, 30), pick_key(), $urandom);
                endcase
            end
        end
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
            begin
                for (int i = 0; i < 40; i++)
                    send_request(pick_op(40, 25, 30), pick_key(), $urandom);
            end
        join
        snk_idle_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
            if (key_pool[i] == SENTINEL_KEY)
                key_pool[i] = 32'hFFFF_FFFE;
        end
        key_pool[0] = '0;
        key_pool[1] = 32'hFFFF_FFFE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_store();
        test_random(10, 100);
        test_backpressure();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked, set reached full %0d times",
                 n_requests, n_results, n_max_fill);
        $display("inserts ok %0d, full rejects %0d, deletes ok %0d, finds ok %0d",
                 n_ins_ok, n_full, n_del_ok, n_find_ok);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
